// ----- rtl/itoa_pkg.sv -----
package itoa_pkg;

    localparam int VALUE_BITS = 32;
    localparam int DIGIT_DEPTH = VALUE_BITS;
    localparam int ADDR_BITS = $clog2(DIGIT_DEPTH);
    localparam int COUNT_BITS = $clog2(DIGIT_DEPTH + 1);
    localparam int BIT_CNT_BITS = $clog2(VALUE_BITS);

    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] RADIX_DECIMAL = 6'd10;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_MINUS = 8'h2d;
    localparam logic [5:0] MAX_DECIMAL_DIGIT = 6'd9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_READ,
        S_LOAD,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [5:0]            divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [5:0]            remainder;
    } div_stat_t;

    function automatic logic [7:0] ascii_of_digit(input logic [5:0] d);
        logic [7:0] code;
        if (d > MAX_DECIMAL_DIGIT) begin
            code = ASCII_LOWER_A + {2'b00, d} - 8'd10;
        end else begin
            code = ASCII_ZERO + {2'b00, d};
        end
        return code;
    endfunction

endpackage

// ----- rtl/itoa_divider.sv -----
module itoa_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  itoa_pkg::div_ctrl_t ctrl,
    output itoa_pkg::div_stat_t stat
);
    import itoa_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [BIT_CNT_BITS-1:0] bit_cnt_reg, bit_cnt_next;
    logic [VALUE_BITS-1:0]   quo_reg, quo_next;
    logic [5:0]              rem_reg, rem_next;
    logic [5:0]              divisor_reg, divisor_next;
    logic [6:0]              trial;
    logic                    fits;

    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign fits = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        bit_cnt_next = bit_cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        divisor_next = divisor_reg;
        if (ctrl.start && !busy_reg) begin
            busy_next = 1'b1;
            bit_cnt_next = '0;
            quo_next = ctrl.dividend;
            rem_next = '0;
            divisor_next = ctrl.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[VALUE_BITS-2:0], fits};
            rem_next = fits ? 6'(trial - {1'b0, divisor_reg}) : trial[5:0];
            bit_cnt_next = bit_cnt_reg + 1'b1;
            if (bit_cnt_reg == BIT_CNT_BITS'(VALUE_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.quotient = quo_reg;
    assign stat.remainder = rem_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("Divider done without a preceding busy cycle.");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < divisor_reg)
        else $error("Divider remainder not below the divisor.");

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> busy_reg || done_reg)
        else $error("Divider left busy without signaling done.");

endmodule

// ----- rtl/integer_to_ascii_any_base.sv -----
// Integer to ASCII converter in a configurable base from 2 to 36.
// The input channel (in_valid, in_ready, value) takes one 32-bit signed item.
// The output channel (out_valid, out_ready, character, last) gives its text,
// one ASCII character per item, most significant first, with last set on the
// final character. In base ten a negative value is led by a '-' character;
// other bases print the value as unsigned.
// The radix register is written through cfg_we and cfg_data; write it only while
// idle, the block itself does not enforce this; codes 0 and 1 act as 2 and codes above 36 act as 36.
// Each digit is one pass of the shared one-bit-per-cycle divider over all
// 32 dividend bits; after the last digit the text is sent, a sign first if
// any, and then each digit through the read, load and emit steps. The worst
// case is base two with 32 digits.
// in_ready is high only while no conversion is in progress.
// When the receiver stalls, the current character is held in the output
// register until it is taken.
// Reset clears the sequencer and sets the radix to ten; no clearing pass
// is needed.
module integer_to_ascii_any_base (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [5:0]                      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [itoa_pkg::VALUE_BITS-1:0] value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      character,
    output logic                            last
);
    import itoa_pkg::*;

    state_t                state_reg, state_next;
    logic [5:0]            radix_reg;
    logic [5:0]            base_reg, base_next;
    logic                  neg_reg, neg_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0] idx_reg, idx_next;
    logic [7:0]            char_reg, char_next;
    logic                  last_reg, last_next;
    logic [5:0]            eff_radix;
    logic                  value_neg;
    logic [VALUE_BITS-1:0] magnitude;
    logic                  in_accept;
    logic                  out_accept;
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [5:0]            rd_data_reg;
    logic [5:0]            digit_mem [DIGIT_DEPTH];
    div_ctrl_t             div_ctrl;
    div_stat_t             div_stat;

    itoa_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat)
    );

    always_comb
    begin
        priority if (radix_reg < RADIX_MIN) begin
            eff_radix = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            eff_radix = RADIX_MAX;
        end else begin
            eff_radix = radix_reg;
        end
    end

    assign value_neg = (eff_radix == RADIX_DECIMAL) && value[VALUE_BITS-1];
    assign magnitude = value_neg ? VALUE_BITS'(-value) : VALUE_BITS'(value);
    assign in_ready = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = (state_reg == S_SIGN) || (state_reg == S_EMIT);
    assign out_accept = out_valid && out_ready;
    assign wr_addr = cnt_reg[ADDR_BITS-1:0];
    assign rd_addr = ADDR_BITS'(idx_reg - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        base_next = base_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        char_next = char_reg;
        last_next = last_reg;
        wr_en = 1'b0;
        div_ctrl.start = 1'b0;
        div_ctrl.dividend = div_stat.quotient;
        div_ctrl.divisor = base_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept) begin
                    base_next = eff_radix;
                    neg_next = value_neg;
                    cnt_next = '0;
                    div_ctrl.start = 1'b1;
                    div_ctrl.dividend = magnitude;
                    div_ctrl.divisor = eff_radix;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done) begin
                    wr_en = 1'b1;
                    if (div_stat.quotient == '0
                        || cnt_reg == COUNT_BITS'(DIGIT_DEPTH - 1)) begin
                        idx_next = cnt_reg + 1'b1;
                        char_next = ASCII_MINUS;
                        last_next = 1'b0;
                        state_next = neg_reg ? S_SIGN : S_READ;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                        div_ctrl.start = 1'b1;
                    end
                end
            end
            S_SIGN:
            begin
                if (out_accept) begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                char_next = ascii_of_digit(rd_data_reg);
                last_next = (idx_reg == COUNT_BITS'(1));
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_accept) begin
                    idx_next = idx_reg - 1'b1;
                    state_next = last_reg ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            radix_reg <= RADIX_RESET;
            cnt_reg <= '0;
            idx_reg <= '0;
            neg_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            neg_reg <= neg_next;
            if (cfg_we) begin
                radix_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            digit_mem[wr_addr] <= div_stat.remainder;
        end
        rd_data_reg <= digit_mem[rd_addr];
    end

    assign character = char_reg;
    assign last = last_reg;

    a_done_only_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV)
        else $error("Divider finished outside the division phase.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ready && div_stat.busy)
        else $error("Conversion did not start after an accepted item.");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_accept && last |=> !out_valid && in_ready)
        else $error("Block not idle after the final character.");

    a_emit_index_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> idx_reg != '0 && last == (idx_reg == COUNT_BITS'(1)))
        else $error("Character index out of step with the last mark.");

endmodule

// ----- verif/tb.sv -----
module tb;
    import itoa_pkg::*;

    typedef struct {
        bit                    is_radix;
        logic [5:0]            radix_code;
        logic [VALUE_BITS-1:0] num;
    } job_t;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [5:0]                   cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic signed [VALUE_BITS-1:0] value = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [7:0]                   character;
    logic                         last;

    job_t        pending_q[$];
    char_t       text_q[$];
    logic [5:0]  radix_now = RADIX_RESET;
    int unsigned items_offered = 0;
    int unsigned items_taken = 0;
    int unsigned mismatches = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          quiet_tail = 1'b0;
    bit          long_hold_done = 1'b0;

    integer_to_ascii_any_base dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void predict_text(input logic [VALUE_BITS-1:0] num);
        logic [31:0]           base;
        logic [VALUE_BITS-1:0] mag;
        logic [5:0]            digits [0:VALUE_BITS-1];
        int                    n;
        bit                    neg;
        char_t                 c;
        if (radix_now < RADIX_MIN)
        begin
            base = 32'(RADIX_MIN);
        end
        else if (radix_now > RADIX_MAX)
        begin
            base = 32'(RADIX_MAX);
        end
        else
        begin
            base = 32'(radix_now);
        end
        mag = num;
        neg = 1'b0;
        if (base == 32'(RADIX_DECIMAL) && num[VALUE_BITS-1])
        begin
            neg = 1'b1;
            mag = -num;
        end
        n = 0;
        do
        begin
            digits[n] = 6'(mag % base);
            n++;
            mag = mag / base;
        end
        while (mag != 0 && n < VALUE_BITS);
        if (neg)
        begin
            c.code = ASCII_MINUS;
            c.last = 1'b0;
            text_q.push_back(c);
        end
        for (int k = n - 1; k >= 0; k--)
        begin
            if (digits[k] > MAX_DECIMAL_DIGIT)
            begin
                c.code = ASCII_LOWER_A + 8'(digits[k]) - 8'd10;
            end
            else
            begin
                c.code = ASCII_ZERO + 8'(digits[k]);
            end
            c.last = (k == 0);
            text_q.push_back(c);
        end
    endfunction

    task automatic push_value(input logic [VALUE_BITS-1:0] num);
        job_t job;
        job.is_radix = 1'b0;
        job.radix_code = '0;
        job.num = num;
        pending_q.push_back(job);
    endtask

    task automatic push_radix(input logic [5:0] code);
        job_t job;
        job.is_radix = 1'b1;
        job.radix_code = code;
        job.num = '0;
        pending_q.push_back(job);
    endtask

    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 40);
            2: v = -32'($urandom_range(1, 1000));
            3: v = 32'h7fff_ffff - $urandom_range(0, 3);
            4: v = 32'h8000_0000 + $urandom_range(0, 3);
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    always @(negedge clk)
    begin : drive
        logic                  next_valid;
        logic [VALUE_BITS-1:0] next_value;
        logic                  next_we;
        logic [5:0]            next_data;
        job_t                  job;
        next_valid = in_valid;
        next_value = value;
        next_we = 1'b0;
        next_data = cfg_data;
        if (rst_n)
        begin
            if (in_valid && items_taken == items_offered)
            begin
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_q.size() > 0)
                begin
                    if (pending_q[0].is_radix)
                    begin
                        // The radix only changes once the block has delivered all text.
                        if (text_q.size() == 0)
                        begin
                            job = pending_q.pop_front();
                            next_we = 1'b1;
                            next_data = job.radix_code;
                            radix_now = job.radix_code;
                        end
                    end
                    else
                    begin
                        job = pending_q.pop_front();
                        next_valid = 1'b1;
                        next_value = job.num;
                        items_offered++;
                        if (!quiet_tail && $urandom_range(0, 2) == 0)
                        begin
                            gap_left = $urandom_range(1, 17);
                        end
                    end
                end
            end
        end
        in_valid <= next_valid;
        value <= next_value;
        cfg_we <= next_we;
        cfg_data <= next_data;
    end

    always @(negedge clk)
    begin : sink
        logic next_ready;
        next_ready = 1'b0;
        if (rst_n)
        begin
            // One long hold-off while the sender is blocked fills the block and stalls its input.
            if (!long_hold_done && items_taken >= 30 && in_valid && !in_ready)
            begin
                long_hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
            end
            else
            begin
                next_ready = 1'b1;
            end
        end
        out_ready <= next_ready;
    end

    always @(posedge clk)
    begin : watch
        char_t want;
        if (rst_n)
        begin
            quiet_tail <= (pending_q.size() < 40);
            if (in_valid && in_ready)
            begin
                predict_text(value);
                items_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (text_q.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("unexpected character %h last %b", character, last);
                    end
                    mismatches++;
                end
                else
                begin
                    want = text_q.pop_front();
                    if (character !== want.code || last !== want.last)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("character mismatch: expected %h last %b, got %h last %b",
                                     want.code, want.last, character, last);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned count;
        int unsigned phase_len;
        logic [5:0]  code;

        push_value(32'd0);
        push_value(32'd1);
        push_value(32'hffff_ffff);
        push_value(32'd9);
        push_value(32'd10);
        push_value(32'h7fff_ffff);
        push_value(32'h8000_0000);
        push_value(-32'd10);
        push_radix(6'd2);
        push_value(32'd0);
        push_value(32'hffff_ffff);
        push_value(32'h8000_0000);
        push_radix(RADIX_MAX);
        push_value(32'd35);
        push_value(32'd36);
        push_value(32'hffff_ffff);
        push_radix(6'd0);
        push_value(32'd5);
        push_value(32'h8000_0000);
        push_radix(6'd1);
        push_value(32'd3);
        push_radix(6'd37);
        push_value(32'd35);
        push_radix(6'd63);
        push_value(32'hffff_ffff);
        push_radix(6'd16);
        push_value(32'hdead_beef);

        count = 0;
        code = RADIX_DECIMAL;
        while (count < 195)
        begin
            push_radix(code);
            phase_len = $urandom_range(6, 24);
            repeat (phase_len)
            begin
                push_value(random_value());
            end
            count += phase_len;
            if ($urandom_range(0, 5) == 0)
            begin
                code = 6'($urandom_range(0, 63));
            end
            else
            begin
                code = 6'($urandom_range(2, 36));
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || in_valid || text_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("[integer_to_ascii_any_base] OK");
        end
        else
        begin
            $display("[integer_to_ascii_any_base] ERROR");
        end
        $finish;
    end

    initial
    begin : watchdog
        #20000000;
        $display("[integer_to_ascii_any_base] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/itoa_pkg.sv
rtl/itoa_divider.sv
rtl/integer_to_ascii_any_base.sv
verif/tb.sv
